FILE: rtl/brep_pkg.sv
// shared constants, register codes and payload types for the region extreme point search
// no dependencies; compiled first
`default_nettype none

package brep_pkg;

    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_HEIGHT_W  = 11;
    localparam int THRESH_W      = 8;
    localparam int MARGIN_W      = 8;
    localparam int CFG_DATA_W    = 11;
    localparam int CFG_INDEX_W   = 2;
    localparam int GRAY_W        = 8;
    localparam int POINT_W       = 10;
    localparam int POINT_INDEX_W = 3;
    localparam int NUM_POINTS    = 6;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH    = 11'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
    localparam logic [THRESH_W-1:0]     RST_DARK_THRESHOLD = 8'd100;
    localparam logic [MARGIN_W-1:0]     RST_EDGE_MARGIN    = 8'd5;

    // slot layout: base slot plus side (0 left, 1 right)
    localparam int PT_TOP       = 0;
    localparam int PT_LEFTMOST  = 2;
    localparam int PT_RIGHTMOST = 4;
    localparam logic [POINT_INDEX_W-1:0] PT_LAST = 3'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_DARK_THRESHOLD = 2'd2,
        REG_EDGE_MARGIN    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GRAY_W-1:0] gray_pixel;
        logic              frame_start;
    } pixel_t;

    typedef struct packed {
        logic [POINT_INDEX_W-1:0] point_index;
        logic [POINT_W-1:0]       point_x;
        logic [POINT_W-1:0]       point_y;
        logic                     point_found;
        logic                     last_point;
    } point_t;

endpackage

`default_nettype wire

FILE: rtl/brep_pixel_if.sv
// valid/ready channel carrying one grey pixel per transfer
// depends on brep_pkg
`default_nettype none

interface brep_pixel_if;
    logic            valid;
    logic            ready;
    brep_pkg::pixel_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/brep_point_if.sv
// valid/ready channel carrying one extreme point result per transfer
// depends on brep_pkg
`default_nettype none

interface brep_point_if;
    logic            valid;
    logic            ready;
    brep_pkg::point_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/binary_region_extreme_points_top.sv
// Region extreme point search over a grey pixel stream.
// Pixels enter in raster order, one transfer per clock while pixels.ready is high.
// Row and column are counted here; frame_start forces the pixel to (0,0).
// Per pixel the dark test, region compares and the six tracker updates are
// one level of compares and muxes into the tracker registers, so a pixel
// is taken every cycle that pixels.ready is high.
// On the last pixel of a frame the six points are copied into a result
// buffer and sent on the points channel from the next clock, one per
// cycle while points.ready is high (indexes 0 to 5, last_point on index 5);
// the next frame is taken meanwhile. If the receiver stalls, results wait
// in the buffer; the pixels channel only holds off while the next pixel
// may end a frame and the previous frame's results are not yet all transferred.
// Configuration is a plain write port; the user writes it only while the block is idle (not enforced).
// Reset loads the register defaults (640, 480, 100, 5), clears counters and
// trackers and empties the result buffer.
// depends on brep_pkg, brep_pixel_if, brep_point_if
`default_nettype none

module binary_region_extreme_points_top #(
    parameter int MAX_WIDTH  = brep_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = brep_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             write_enable,
    input  wire logic [brep_pkg::CFG_INDEX_W-1:0] reg_index,
    input  wire logic [brep_pkg::CFG_DATA_W-1:0]  write_data,
    brep_pixel_if.sink                            pixels,
    brep_point_if.source                          points
);
    import brep_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_WIDTH_W) ?
                        $clog2(MAX_WIDTH + 1) : CFG_WIDTH_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > CFG_HEIGHT_W) ?
                        $clog2(MAX_HEIGHT + 1) : CFG_HEIGHT_W;

    // configuration
    logic [CFG_WIDTH_W-1:0]  image_width_reg;
    logic [CFG_HEIGHT_W-1:0] image_height_reg;
    logic [THRESH_W-1:0]     dark_threshold_reg;
    logic [MARGIN_W-1:0]     edge_margin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= RST_IMAGE_WIDTH;
            image_height_reg   <= RST_IMAGE_HEIGHT;
            dark_threshold_reg <= RST_DARK_THRESHOLD;
            edge_margin_reg    <= RST_EDGE_MARGIN;
        end
        else if (write_enable)
        begin
            case (cfg_reg_t'(reg_index))
                REG_IMAGE_WIDTH:    image_width_reg    <= write_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   image_height_reg   <= write_data[CFG_HEIGHT_W-1:0];
                REG_DARK_THRESHOLD: dark_threshold_reg <= write_data[THRESH_W-1:0];
                REG_EDGE_MARGIN:    edge_margin_reg    <= write_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size
    logic [WW-1:0] w_raw, w_clamp, half_w;
    logic [HW-1:0] h_raw, h_clamp, half_h;

    always_comb
    begin
        w_raw = WW'(image_width_reg);
        h_raw = HW'(image_height_reg);
        if (w_raw == '0)
            w_clamp = WW'(1);
        else if (w_raw > WW'(MAX_WIDTH))
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = w_raw;
        if (h_raw == '0)
            h_clamp = HW'(1);
        else if (h_raw > HW'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = h_raw;
        half_w = w_clamp >> 1;
        half_h = h_clamp >> 1;
    end

    // position and tracker state
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      trk_x_reg     [NUM_POINTS];
    logic [CW-1:0]      trk_x_next    [NUM_POINTS];
    logic [RW-1:0]      trk_y_reg     [NUM_POINTS];
    logic [RW-1:0]      trk_y_next    [NUM_POINTS];
    logic [NUM_POINTS-1:0] trk_valid_reg, trk_valid_next;

    // result buffer
    logic [CW-1:0]         snap_x_reg [NUM_POINTS];
    logic [RW-1:0]         snap_y_reg [NUM_POINTS];
    logic [NUM_POINTS-1:0] snap_found_reg;
    logic                  busy_reg, busy_next;
    logic [POINT_INDEX_W-1:0] slot_reg, slot_next;

    logic          start;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic [WW:0]   col_ext, col_reg_ext;
    logic [HW:0]   row_ext, row_reg_ext;
    logic          dark, in_top, left_cond, right_cond;
    logic [1:0]    hit;
    logic          last_col, last_row, eof;
    logic          end_possible, buf_free;
    logic          xfer_in, xfer_out;
    logic [NUM_POINTS-1:0] upd_valid;
    logic [CW-1:0]         upd_x [NUM_POINTS];
    logic [RW-1:0]         upd_y [NUM_POINTS];

    always_comb
    begin
        start   = pixels.data.frame_start;
        col     = start ? '0 : col_reg;
        row     = start ? '0 : row_reg;
        col_ext = (WW+1)'(col);
        row_ext = (HW+1)'(row);

        dark      = pixels.data.gray_pixel < dark_threshold_reg;
        in_top    = row_ext < (HW+1)'(half_h);
        left_cond = (col_ext >= (WW+1)'(edge_margin_reg)) && (col_ext < (WW+1)'(half_w));
        right_cond = !left_cond && (col_ext >= (WW+1)'(half_w)) &&
                     ((col_ext + (WW+1)'(edge_margin_reg)) < (WW+1)'(w_clamp));
        hit[0] = dark && in_top && left_cond;
        hit[1] = dark && in_top && right_cond;

        last_col = (col_ext + (WW+1)'(1)) >= (WW+1)'(w_clamp);
        last_row = (row_ext + (HW+1)'(1)) >= (HW+1)'(h_clamp);
        eof      = last_col && last_row;

        // frame end reachable whatever frame_start says, so ready ignores payload
        col_reg_ext  = (WW+1)'(col_reg);
        row_reg_ext  = (HW+1)'(row_reg);
        end_possible = (((col_reg_ext + (WW+1)'(1)) >= (WW+1)'(w_clamp)) &&
                        ((row_reg_ext + (HW+1)'(1)) >= (HW+1)'(h_clamp))) ||
                       ((w_clamp == WW'(1)) && (h_clamp == HW'(1)));
        buf_free     = !busy_reg || ((slot_reg == PT_LAST) && points.ready);
    end

    assign pixels.ready = buf_free || !end_possible;
    assign xfer_in      = pixels.valid && pixels.ready;
    assign xfer_out     = points.valid && points.ready;

    // tracker update: frame start clears before this pixel is applied
    always_comb
    begin
        for (int k = 0; k < NUM_POINTS; k++)
        begin
            upd_valid[k] = start ? 1'b0 : trk_valid_reg[k];
            upd_x[k]     = start ? '0 : trk_x_reg[k];
            upd_y[k]     = start ? '0 : trk_y_reg[k];
        end
        for (int s = 0; s < 2; s++)
        begin
            if (hit[s])
            begin
                if (!upd_valid[PT_TOP + s])
                begin
                    upd_valid[PT_TOP + s] = 1'b1;
                    upd_x[PT_TOP + s]     = col;
                    upd_y[PT_TOP + s]     = row;
                end
                if (!upd_valid[PT_LEFTMOST + s] || (col < upd_x[PT_LEFTMOST + s]))
                begin
                    upd_valid[PT_LEFTMOST + s] = 1'b1;
                    upd_x[PT_LEFTMOST + s]     = col;
                    upd_y[PT_LEFTMOST + s]     = row;
                end
                if (!upd_valid[PT_RIGHTMOST + s] || (col > upd_x[PT_RIGHTMOST + s]))
                begin
                    upd_valid[PT_RIGHTMOST + s] = 1'b1;
                    upd_x[PT_RIGHTMOST + s]     = col;
                    upd_y[PT_RIGHTMOST + s]     = row;
                end
            end
        end
    end

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        trk_valid_next = trk_valid_reg;
        trk_x_next     = trk_x_reg;
        trk_y_next     = trk_y_reg;
        if (xfer_in)
        begin
            if (eof)
            begin
                col_next       = '0;
                row_next       = '0;
                trk_valid_next = '0;
                for (int k = 0; k < NUM_POINTS; k++)
                begin
                    trk_x_next[k] = '0;
                    trk_y_next[k] = '0;
                end
            end
            else
            begin
                if (last_col)
                begin
                    col_next = '0;
                    row_next = RW'(row_ext + (HW+1)'(1));
                end
                else
                begin
                    col_next = CW'(col_ext + (WW+1)'(1));
                    row_next = row;
                end
                trk_valid_next = upd_valid;
                trk_x_next     = upd_x;
                trk_y_next     = upd_y;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        slot_next = slot_reg;
        if (xfer_in && eof)
        begin
            busy_next = 1'b1;
            slot_next = '0;
        end
        else if (xfer_out)
        begin
            if (slot_reg == PT_LAST)
                busy_next = 1'b0;
            else
                slot_next = slot_reg + POINT_INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            trk_valid_reg <= '0;
            busy_reg      <= 1'b0;
            slot_reg      <= '0;
            for (int k = 0; k < NUM_POINTS; k++)
            begin
                trk_x_reg[k] <= '0;
                trk_y_reg[k] <= '0;
            end
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            trk_valid_reg <= trk_valid_next;
            trk_x_reg     <= trk_x_next;
            trk_y_reg     <= trk_y_next;
            busy_reg      <= busy_next;
            slot_reg      <= slot_next;
        end
    end

    // snapshot taken with the frame's last pixel already applied
    always_ff @(posedge clk)
    begin
        if (xfer_in && eof)
        begin
            snap_found_reg <= upd_valid;
            snap_x_reg     <= upd_x;
            snap_y_reg     <= upd_y;
        end
    end

    logic slot_found;

    always_comb
    begin
        slot_found               = snap_found_reg[slot_reg];
        points.valid             = busy_reg;
        points.data.point_index  = slot_reg;
        points.data.point_found  = slot_found;
        points.data.point_x      = slot_found ? POINT_W'(snap_x_reg[slot_reg]) : '0;
        points.data.point_y      = slot_found ? POINT_W'(snap_y_reg[slot_reg]) : '0;
        points.data.last_point   = (slot_reg == PT_LAST);
    end

endmodule

`default_nettype wire
